/* design/binary_to_decimal_ascii_core_macros.svh */
// assertion macros for the binary to decimal ascii core
// used by the top level only; needs i_clk and i_rst_n in scope
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// same-cycle implication
`define B2DA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b2da check failed");

// next-cycle implication
`define B2DA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b2da check failed");

`endif

/* design/b2da_pkg.sv */
// shared constants and types for the binary to decimal ascii core
// no dependencies
`default_nettype none

package b2da_pkg;

    localparam int MAX_DIGITS  = 10;
    localparam int VALUE_BITS  = 32;
    localparam int BCD_W       = MAX_DIGITS * 4;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int CHAR_W      = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } t_handoff;

endpackage

`default_nettype wire

/* design/binary_to_decimal_ascii_core.sv */
// binary to decimal ascii core: 32-bit unsigned in, ascii digits out, msd first
// after a request is accepted, the first character follows the bit shifts, the
// handoff and the output register; further characters one per cycle without stall
// the bit-serial bcd converter takes no new request until its digits are handed off
// the converter takes the next request while the emitter sends the previous digits
// reset: synchronous active-low i_rst_n clears control state, block idle and empty
`default_nettype none
`include "binary_to_decimal_ascii_core_macros.svh"

module binary_to_decimal_ascii_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [b2da_pkg::VALUE_BITS-1:0]  i_value,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]           o_digit_char,
    output logic                                  o_last
);
    import b2da_pkg::*;

    t_handoff hand;
    logic     take;

    b2da_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_hand  (hand),
        .i_take  (take)
    );

    b2da_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hand       (hand),
        .o_take       (take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    `B2DA_ASSERT_NEXT(a_busy_after_req, i_valid && !o_stall, o_stall)
    `B2DA_ASSERT_NOW(a_char_range, o_valid,
        (o_digit_char >= ASCII_ZERO) && (o_digit_char <= ASCII_ZERO + CHAR_W'(9)))
    `B2DA_ASSERT_NEXT(a_take_frees_converter, take, !hand.valid)
    `B2DA_ASSERT_NOW(a_take_needs_done, take, hand.valid && o_stall)

endmodule

`default_nettype wire

/* design/b2da_dabble.sv */
// bit-serial binary to bcd converter, shift and add-3, one input bit per cycle
// depends on b2da_pkg
`default_nettype none

module b2da_dabble (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [b2da_pkg::VALUE_BITS-1:0]  i_value,
    output b2da_pkg::t_handoff                    o_hand,
    input  wire logic                             i_take
);
    import b2da_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_DONE  = 3'b100
    } t_cvt_state;

    t_cvt_state             r_state, n_state;
    logic [BIT_CNT_W-1:0]   r_bits, n_bits;
    logic [VALUE_BITS-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       adj;

    always_comb begin
        logic [3:0] d;
        adj = r_bcd;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            d = r_bcd[i*4 +: 4];
            adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bits  = r_bits;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SHIFT;
                    n_bits  = BIT_CNT_W'(VALUE_BITS);
                    n_bin   = i_value;
                    n_bcd   = '0;
                end
            end
            S_SHIFT: begin
                n_bcd  = {adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_bits = r_bits - BIT_CNT_W'(1);
                if (r_bits == BIT_CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_hand.valid = (r_state == S_DONE);
    assign o_hand.bcd   = r_bcd;

endmodule

`default_nettype wire

/* design/b2da_emit.sv */
// digit emitter: holds one number's bcd digits and sends them as ascii, msd first
// depends on b2da_pkg
`default_nettype none

module b2da_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire b2da_pkg::t_handoff            i_hand,
    output logic                               o_take,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]        o_digit_char,
    output logic                               o_last
);
    import b2da_pkg::*;

    logic [BCD_W-1:0]        r_bcd;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_valid;
    logic [CHAR_W-1:0]       r_char;
    logic                    r_last;
    logic [CNT_W-1:0]        lead_cnt;
    logic [DIGIT_IDX_W-1:0]  idx;
    logic [3:0]              cur_digit;
    logic                    send;

    // number of significant digits, at least one
    always_comb begin
        lead_cnt = CNT_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i_hand.bcd[i*4 +: 4] != 4'd0) begin
                lead_cnt = CNT_W'(i + 1);
            end
        end
    end

    assign o_take    = i_hand.valid && (r_cnt == '0);
    assign send      = (r_cnt != '0) && (!r_valid || !i_stall);
    assign idx       = DIGIT_IDX_W'(r_cnt - CNT_W'(1));
    assign cur_digit = r_bcd[idx*4 +: 4];

    always_comb begin
        n_cnt = r_cnt;
        if (o_take) begin
            n_cnt = lead_cnt;
        end else if (send) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (send) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (o_take) begin
            r_bcd <= i_hand.bcd;
        end
        if (send) begin
            r_char <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
            r_last <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

endmodule

`default_nettype wire
